// ===== sv/kwm_pkg.sv =====
`default_nettype none
package kwm_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 32;
  localparam int SID_W = 3;
  localparam int CNT_W = 4;

  localparam logic [CNT_W-1:0] COUNT_RESET = 4'd8;

  typedef enum logic {
    MODE_DELIVER = 1'b0,
    MODE_EXHAUST = 1'b1
  } mode_t;

  // one held head record
  typedef struct packed {
    logic                    valid;
    logic [SID_W-1:0]        stream;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic             ins;
    entry_t           ins_entry;
    logic             del_en;
    logic [SID_W-1:0] del_stream;
    logic             emit;
    logic             sorting;
    logic [CNT_W-1:0] neff;
  } ctrl_t;

  // stream at or above the live count
  function automatic logic beyond(logic [SID_W-1:0] s, logic [CNT_W-1:0] n);
    return CNT_W'(s) >= n;
  endfunction

  // order: live streams first, then signed key, then stream index
  function automatic logic rank_less(entry_t a, entry_t b, logic [CNT_W-1:0] n);
    logic [KEY_W+SID_W:0] ra;
    logic [KEY_W+SID_W:0] rb;
    ra = {beyond(a.stream, n), ~a.key[KEY_W-1], a.key[KEY_W-2:0], a.stream};
    rb = {beyond(b.stream, n), ~b.key[KEY_W-1], b.key[KEY_W-2:0], b.stream};
    return ra < rb;
  endfunction

endpackage
`default_nettype wire

// ===== sv/kwm_if.sv =====
`default_nettype none
// request channel into the merge
interface kwm_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [kwm_pkg::SID_W-1:0]       stream_id;
  logic signed [kwm_pkg::KEY_W-1:0] record_key;
  logic [kwm_pkg::TAG_W-1:0]       record_tag;

  modport source (output valid, mode, stream_id, record_key, record_tag, input ready);
  modport sink (input valid, mode, stream_id, record_key, record_tag, output ready);
endinterface

// merged record channel out of the merge
interface kwm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [kwm_pkg::KEY_W-1:0] out_key;
  logic [kwm_pkg::TAG_W-1:0]        out_tag;
  logic [kwm_pkg::SID_W-1:0]        out_stream;

  modport source (output valid, out_key, out_tag, out_stream, input ready);
  modport sink (input valid, out_key, out_tag, out_stream, output ready);
endinterface
`default_nettype wire

// ===== sv/k_way_sorted_stream_merge.sv =====
`default_nettype none
// channel   | direction | fields
// ----------+-----------+--------------------------------------------------
// in_ch     | sink      | mode, stream_id, record_key, record_tag
// out_ch    | source    | out_key, out_tag, out_stream
// cfg_wr_*  | write     | stream_count (4 bits)
//
// one request per cycle while in_ch.ready is high; a merged record appears in the
// cycle after the request that releases it, from the output register.
// the held heads sit in a sorted row of MAX_STREAMS cells, so outside a re-sort
// the smallest is in the first cell; insert, overwrite and emit act on the row together.
// after a stream_count write the row re-sorts by neighbour compare-exchange passes
// with in_ch.ready low.
// reset (synchronous) empties all slots and sets stream_count to 8.
// in_ch.ready is low only while a re-sort runs or a result waits untaken.
module k_way_sorted_stream_merge #(
  parameter int MAX_STREAMS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [kwm_pkg::CNT_W-1:0]   cfg_wr_data,
  kwm_in_if.sink                      in_ch,
  kwm_out_if.source                   out_ch
);

  localparam int SW  = $clog2(MAX_STREAMS);
  localparam int SCW = $clog2(MAX_STREAMS + 1);

  logic [kwm_pkg::CNT_W-1:0] stream_count;
  logic [kwm_pkg::CNT_W-1:0] neff;
  logic [SCW-1:0]            sort_cnt;
  logic                      sorting;

  logic [MAX_STREAMS-1:0] full;
  logic [MAX_STREAMS-1:0] done;
  logic [MAX_STREAMS-1:0] full_upd;
  logic [MAX_STREAMS-1:0] done_upd;
  logic [MAX_STREAMS-1:0] full_next;
  logic [MAX_STREAMS-1:0] inuse;
  logic [MAX_STREAMS-1:0] sid_hot;
  logic [MAX_STREAMS-1:0] emit_hot;

  logic          accept;
  logic          sid_ok;
  logic          ins;
  logic          mark;
  logic          ovw;
  logic          all_ready;
  logic          front_live;
  logic          emit;
  logic [SW-1:0] sid_idx;
  logic [SW-1:0] front_idx;

  kwm_pkg::ctrl_t ctrl;

  logic                   out_valid;
  kwm_pkg::entry_t        out_entry;

  kwm_pkg::entry_t        slot     [MAX_STREAMS];
  kwm_pkg::entry_t        comp     [MAX_STREAMS];
  kwm_pkg::entry_t        merged   [MAX_STREAMS];
  kwm_pkg::entry_t        l_slot   [MAX_STREAMS];
  kwm_pkg::entry_t        r_slot   [MAX_STREAMS];
  kwm_pkg::entry_t        l_comp   [MAX_STREAMS];
  kwm_pkg::entry_t        r_merged [MAX_STREAMS];
  logic [MAX_STREAMS-1:0] hit;
  logic [MAX_STREAMS-1:0] lt;
  logic [MAX_STREAMS-1:0] comp_lt;
  logic [MAX_STREAMS-1:0] swap;
  logic [MAX_STREAMS-1:0] shift;
  logic [MAX_STREAMS-1:0] pair_left;
  logic [MAX_STREAMS-1:0] r_lt;
  logic [MAX_STREAMS-1:0] l_comp_lt;
  logic [MAX_STREAMS-1:0] l_swap;
  logic [MAX_STREAMS-1:0] slot_valid;

  // live stream count, clamped
  always_comb begin
    if (stream_count == '0) begin
      neff = kwm_pkg::CNT_W'(1);
    end else if (int'(stream_count) > MAX_STREAMS) begin
      neff = kwm_pkg::CNT_W'(MAX_STREAMS);
    end else begin
      neff = stream_count;
    end
  end

  // configuration register and re-sort counter
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_count <= kwm_pkg::COUNT_RESET;
      sort_cnt     <= '0;
    end else if (cfg_wr_en) begin
      stream_count <= cfg_wr_data;
      sort_cnt     <= SCW'(MAX_STREAMS);
    end else if (sorting) begin
      sort_cnt <= sort_cnt - SCW'(1);
    end
  end

  assign sorting = (sort_cnt != '0);

  // request decode
  assign in_ch.ready = !sorting && (!out_valid || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign sid_idx     = SW'(in_ch.stream_id);
  assign sid_ok      = (kwm_pkg::CNT_W'(in_ch.stream_id) < neff) && !done[sid_idx];
  assign ins         = accept && sid_ok && (in_ch.mode == kwm_pkg::MODE_DELIVER);
  assign mark        = accept && sid_ok && (in_ch.mode == kwm_pkg::MODE_EXHAUST);
  assign ovw         = ins && full[sid_idx];

  always_comb begin
    sid_hot          = '0;
    sid_hot[sid_idx] = 1'b1;
  end

  assign full_upd = full | (ins ? sid_hot : '0);
  assign done_upd = done | (mark ? sid_hot : '0);

  for (genvar i = 0; i < MAX_STREAMS; i++) begin : g_use
    assign inuse[i] = (i < int'(neff));
  end

  // emission: every live stream holds a head or is exhausted
  assign all_ready  = &(full_upd | done_upd | ~inuse);
  assign front_live = merged[0].valid && !kwm_pkg::beyond(merged[0].stream, neff);
  assign emit       = accept && all_ready && front_live;
  assign front_idx  = SW'(merged[0].stream);

  always_comb begin
    emit_hot            = '0;
    emit_hot[front_idx] = emit;
  end

  assign full_next = full_upd & ~emit_hot;

  // per-stream flags
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= '0;
      done <= '0;
    end else begin
      full <= full_next;
      done <= done_upd;
    end
  end

  // broadcast control
  always_comb begin
    ctrl                  = '0;
    ctrl.ins              = ins;
    ctrl.ins_entry.valid  = 1'b1;
    ctrl.ins_entry.stream = in_ch.stream_id;
    ctrl.ins_entry.key    = in_ch.record_key;
    ctrl.ins_entry.tag    = in_ch.record_tag;
    ctrl.del_en           = ovw;
    ctrl.del_stream       = in_ch.stream_id;
    ctrl.emit             = emit;
    ctrl.sorting          = sorting;
    ctrl.neff             = neff;
  end

  // row of head cells with neighbour links
  for (genvar i = 0; i < MAX_STREAMS; i++) begin : g_row
    assign shift[i]      = |hit[i:0];
    assign pair_left[i]  = (1'(i % 2) == sort_cnt[0]);
    assign slot_valid[i] = slot[i].valid;

    if (i == 0) begin : g_first
      assign l_slot[i]    = '0;
      assign l_comp[i]    = '0;
      assign l_comp_lt[i] = 1'b1;
      assign l_swap[i]    = 1'b0;
    end else begin : g_mid_l
      assign l_slot[i]    = slot[i-1];
      assign l_comp[i]    = comp[i-1];
      assign l_comp_lt[i] = comp_lt[i-1];
      assign l_swap[i]    = swap[i-1];
    end

    if (i == MAX_STREAMS - 1) begin : g_last
      assign r_slot[i]   = '0;
      assign r_lt[i]     = 1'b0;
      assign r_merged[i] = '0;
    end else begin : g_mid_r
      assign r_slot[i]   = slot[i+1];
      assign r_lt[i]     = lt[i+1];
      assign r_merged[i] = merged[i+1];
    end

    kwm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .pair_left    (pair_left[i]),
      .shift_in     (shift[i]),
      .left_slot    (l_slot[i]),
      .right_slot   (r_slot[i]),
      .right_lt     (r_lt[i]),
      .left_comp    (l_comp[i]),
      .left_comp_lt (l_comp_lt[i]),
      .right_merged (r_merged[i]),
      .left_swap    (l_swap[i]),
      .slot         (slot[i]),
      .hit          (hit[i]),
      .lt           (lt[i]),
      .comp         (comp[i]),
      .comp_lt      (comp_lt[i]),
      .merged       (merged[i]),
      .swap         (swap[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_entry <= merged[0];
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.out_key    = out_entry.key;
  assign out_ch.out_tag    = out_entry.tag;
  assign out_ch.out_stream = out_entry.stream;

  // row holds exactly the full slots
  assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == $countones(full))
    else $error("head row out of step with full flags");

  // the second cell of the row is filled only when the first one is
  assert property (@(posedge clk) disable iff (rst)
    slot_valid[1] |-> slot_valid[0])
    else $error("gap at the front of the head row");

  // an emitted head came from a full slot
  assert property (@(posedge clk) disable iff (rst)
    emit |-> full_upd[front_idx])
    else $error("emitted head from an empty slot");

  // a new result only follows an accepted request
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept))
    else $error("result without a request");

endmodule
`default_nettype wire

// ===== sv/kwm_cell.sv =====
`default_nettype none
module kwm_cell (
  input  logic             clk,
  input  logic             rst,
  input  kwm_pkg::ctrl_t   ctrl,
  input  logic             pair_left,
  input  logic             shift_in,
  input  kwm_pkg::entry_t  left_slot,
  input  kwm_pkg::entry_t  right_slot,
  input  logic             right_lt,
  input  kwm_pkg::entry_t  left_comp,
  input  logic             left_comp_lt,
  input  kwm_pkg::entry_t  right_merged,
  input  logic             left_swap,
  output kwm_pkg::entry_t  slot,
  output logic             hit,
  output logic             lt,
  output kwm_pkg::entry_t  comp,
  output logic             comp_lt,
  output kwm_pkg::entry_t  merged,
  output logic             swap
);

  kwm_pkg::entry_t slot_next;

  // own compares against the incoming head and the overwrite target
  assign hit = ctrl.del_en & slot.valid & (slot.stream == ctrl.del_stream);
  assign lt  = slot.valid & kwm_pkg::rank_less(slot, ctrl.ins_entry, ctrl.neff);

  // close the gap left by an overwritten head
  assign comp    = shift_in ? right_slot : slot;
  assign comp_lt = shift_in ? right_lt : lt;

  // open a gap for the incoming head
  always_comb begin
    if (!ctrl.ins || comp_lt) begin
      merged = comp;
    end else if (left_comp_lt) begin
      merged = ctrl.ins_entry;
    end else begin
      merged = left_comp;
    end
  end

  // compare-exchange with the right neighbour during a re-sort pass
  assign swap = pair_left & right_slot.valid &
                (!slot.valid | kwm_pkg::rank_less(right_slot, slot, ctrl.neff));

  always_comb begin
    if (ctrl.sorting) begin
      if (swap) begin
        slot_next = right_slot;
      end else if (!pair_left && left_swap) begin
        slot_next = left_slot;
      end else begin
        slot_next = slot;
      end
    end else if (ctrl.emit) begin
      slot_next = right_merged;
    end else begin
      slot_next = merged;
    end
  end

  // slot register, only the valid flag is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule
`default_nettype wire
